FILE: rtl/core/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the tangent basis block
// Field widths, fixed-point alignment, term codes and the MAC control bundle.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int IN_W      = 16;              // corner field width
  localparam int DELTA_W   = IN_W + 1;        // edge delta width
  localparam int PROD_W    = 2 * DELTA_W;     // one product
  localparam int ACC_W     = PROD_W + 1;      // difference of two products
  localparam int OUT_W     = 32;              // Q15.16 result
  localparam int NUM_SHIFT = 20;              // numerator alignment
  localparam int LOW_W     = OUT_W - NUM_SHIFT;
  localparam int HI_W      = ACC_W - LOW_W;
  localparam int STEP_W    = $clog2(OUT_W);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(OUT_W - 1);

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // product terms, in evaluation order
  localparam logic [2:0] TERM_DET = 3'd0;
  localparam logic [2:0] TERM_TX  = 3'd1;
  localparam logic [2:0] TERM_TY  = 3'd2;
  localparam logic [2:0] TERM_TZ  = 3'd3;
  localparam logic [2:0] TERM_BX  = 3'd4;
  localparam logic [2:0] TERM_BY  = 3'd5;
  localparam logic [2:0] TERM_BZ  = 3'd6;

  typedef struct packed {
    logic load;   // acc takes the registered product
    logic sub;    // acc subtracts the registered product
  } mac_ctrl_t;

endpackage

FILE: rtl/core/ttb_corner_if.sv
// ----------------------------------------------------------------------------
// ttb_corner_if: corner request channel
// Valid/ready handshake carrying one triangle corner.
// ----------------------------------------------------------------------------
interface ttb_corner_if;
  logic                             valid;
  logic                             ready;
  logic signed [ttb_pkg::IN_W-1:0]  pos_x;
  logic signed [ttb_pkg::IN_W-1:0]  pos_y;
  logic signed [ttb_pkg::IN_W-1:0]  pos_z;
  logic signed [ttb_pkg::IN_W-1:0]  tex_u;
  logic signed [ttb_pkg::IN_W-1:0]  tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: rtl/core/ttb_basis_if.sv
// ----------------------------------------------------------------------------
// ttb_basis_if: tangent basis request channel
// Valid/ready handshake carrying one tangent/bitangent pair.
// ----------------------------------------------------------------------------
interface ttb_basis_if;
  logic                             valid;
  logic                             ready;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_x;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_y;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_z;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_x;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_y;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_z;
  logic                             degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, degenerate, output ready);
endinterface

FILE: rtl/core/ttb_mac.sv
// ----------------------------------------------------------------------------
// ttb_mac: shared multiply / subtract unit
// Registered 17x17 product feeding an accumulator that forms a*b - c*d.
// ----------------------------------------------------------------------------
module ttb_mac (
  input  logic                                clk,
  input  ttb_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [ttb_pkg::DELTA_W-1:0]  a,
  input  logic signed [ttb_pkg::DELTA_W-1:0]  b,
  output logic signed [ttb_pkg::ACC_W-1:0]    acc
);

  logic signed [ttb_pkg::PROD_W-1:0] prod;
  logic signed [ttb_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = ttb_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= ttb_pkg::PROD_W'(a) * ttb_pkg::PROD_W'(b);
    if (ctrl.load) begin
      acc <= prod_ext;
    end else if (ctrl.sub) begin
      acc <= acc - prod_ext;
    end
  end

endmodule

FILE: rtl/core/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div: bit-serial fixed-point divider
// (num << 20) / den, truncated toward zero, saturated to Q15.16, one bit a cycle.
// ----------------------------------------------------------------------------
module ttb_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ttb_pkg::ACC_W-1:0]   num,
  input  logic signed [ttb_pkg::ACC_W-1:0]   den,
  output logic                               done,
  output logic signed [ttb_pkg::OUT_W-1:0]   quo
);

  logic                          busy;
  logic                          fin;
  logic [ttb_pkg::STEP_W-1:0]    cnt;
  logic [ttb_pkg::ACC_W-1:0]     rem;
  logic [ttb_pkg::OUT_W-1:0]     sh;
  logic [ttb_pkg::OUT_W-1:0]     q;
  logic [ttb_pkg::ACC_W-1:0]     dm;
  logic                          neg;
  logic                          sat;

  logic [ttb_pkg::ACC_W-1:0]     num_mag;
  logic [ttb_pkg::ACC_W-1:0]     den_mag;
  logic [ttb_pkg::HI_W-1:0]      num_hi;
  logic [ttb_pkg::ACC_W:0]       trial;
  logic [ttb_pkg::ACC_W:0]       diff;
  logic                          ge;

  always_comb begin
    num_mag = num[ttb_pkg::ACC_W-1] ? (~num + ttb_pkg::ACC_W'(1'b1)) : num;
    den_mag = den[ttb_pkg::ACC_W-1] ? (~den + ttb_pkg::ACC_W'(1'b1)) : den;
    num_hi  = num_mag[ttb_pkg::ACC_W-1:ttb_pkg::LOW_W];
    trial   = {rem, sh[ttb_pkg::OUT_W-1]};
    diff    = trial - {1'b0, dm};
    ge      = trial >= {1'b0, dm};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + ttb_pkg::STEP_W'(1'b1);
        if (cnt == ttb_pkg::STEP_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // top bits of the shifted dividend seed the remainder
      rem <= ttb_pkg::ACC_W'(num_hi);
      sh  <= {num_mag[ttb_pkg::LOW_W-1:0], {ttb_pkg::NUM_SHIFT{1'b0}}};
      dm  <= den_mag;
      neg <= num[ttb_pkg::ACC_W-1] ^ den[ttb_pkg::ACC_W-1];
      sat <= ttb_pkg::ACC_W'(num_hi) >= den_mag;
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[ttb_pkg::ACC_W-1:0] : trial[ttb_pkg::ACC_W-1:0];
      sh  <= {sh[ttb_pkg::OUT_W-2:0], 1'b0};
      q   <= {q[ttb_pkg::OUT_W-2:0], ge};
    end
  end

  always_comb begin
    if (sat) begin
      quo = neg ? ttb_pkg::SAT_NEG : ttb_pkg::SAT_POS;
    end else if (neg) begin
      quo = q[ttb_pkg::OUT_W-1] ? ttb_pkg::SAT_NEG : -q;
    end else begin
      quo = q[ttb_pkg::OUT_W-1] ? ttb_pkg::SAT_POS : q;
    end
  end

  assign done = fin;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a completed run");

endmodule

FILE: rtl/core/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent
// Collects three corners and forms the tangent basis with a shared MAC and a
// shared serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  corner    in   valid/ready   pos_x/y/z Q7.8, tex_u/v Q3.12
//  basis     out  valid/ready   tangent/bitangent x/y/z Q15.16, degenerate
//
//  First and second corner of a triangle: taken when offered while idle.
//  Third corner: determinant, then the bit-serial divider (32 steps) once
//  for each of the six vector components; none for a zero determinant.
//  The result sits in an output register, so corners of the next triangle
//  are taken while it waits. Reset clears the sequencer and corner count.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
  input  logic               clk,
  input  logic               rst,
  ttb_corner_if.sink         corner,
  ttb_basis_if.source        basis
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] term;
  logic [1:0] corner_count;
  logic       out_valid;
  logic       accept;

  logic signed [ttb_pkg::IN_W-1:0]    in_pos [3];
  logic signed [ttb_pkg::IN_W-1:0]    in_tex [2];
  logic signed [ttb_pkg::IN_W-1:0]    first_pos [3];
  logic signed [ttb_pkg::IN_W-1:0]    first_tex [2];
  logic signed [ttb_pkg::IN_W-1:0]    second_pos [3];
  logic signed [ttb_pkg::IN_W-1:0]    second_tex [2];

  logic signed [ttb_pkg::DELTA_W-1:0] dp1 [3];
  logic signed [ttb_pkg::DELTA_W-1:0] dp2 [3];
  logic signed [ttb_pkg::DELTA_W-1:0] du1, dv1, du2, dv2;

  logic signed [ttb_pkg::DELTA_W-1:0] op0_a, op0_b, op1_a, op1_b;
  logic signed [ttb_pkg::DELTA_W-1:0] mac_a, mac_b;
  ttb_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [ttb_pkg::ACC_W-1:0]   acc;
  logic signed [ttb_pkg::ACC_W-1:0]   det;

  logic                               div_start;
  logic                               div_done;
  logic signed [ttb_pkg::OUT_W-1:0]   div_quo;

  logic signed [ttb_pkg::OUT_W-1:0]   res [6];
  logic [2:0]                         res_idx;
  logic                               degen;
  logic signed [ttb_pkg::OUT_W-1:0]   out_vec [6];
  logic                               out_degen;

  function automatic logic signed [ttb_pkg::DELTA_W-1:0] delta(
    input logic signed [ttb_pkg::IN_W-1:0] a,
    input logic signed [ttb_pkg::IN_W-1:0] b
  );
    return ttb_pkg::DELTA_W'(a) - ttb_pkg::DELTA_W'(b);
  endfunction

  assign accept       = corner.valid && corner.ready;
  assign corner.ready = (state == S_IDLE);

  always_comb begin
    in_pos[0] = corner.pos_x;
    in_pos[1] = corner.pos_y;
    in_pos[2] = corner.pos_z;
    in_tex[0] = corner.tex_u;
    in_tex[1] = corner.tex_v;
  end

  // operand pairs for a*b - c*d of each term
  always_comb begin
    unique case (term)
      ttb_pkg::TERM_DET: begin
        op0_a = du1;    op0_b = dv2;  op1_a = dv1;    op1_b = du2;
      end
      ttb_pkg::TERM_TX: begin
        op0_a = dp1[0]; op0_b = dv2;  op1_a = dp2[0]; op1_b = dv1;
      end
      ttb_pkg::TERM_TY: begin
        op0_a = dp1[1]; op0_b = dv2;  op1_a = dp2[1]; op1_b = dv1;
      end
      ttb_pkg::TERM_TZ: begin
        op0_a = dp1[2]; op0_b = dv2;  op1_a = dp2[2]; op1_b = dv1;
      end
      ttb_pkg::TERM_BX: begin
        op0_a = dp2[0]; op0_b = du1;  op1_a = dp1[0]; op1_b = du2;
      end
      ttb_pkg::TERM_BY: begin
        op0_a = dp2[1]; op0_b = du1;  op1_a = dp1[1]; op1_b = du2;
      end
      ttb_pkg::TERM_BZ: begin
        op0_a = dp2[2]; op0_b = du1;  op1_a = dp1[2]; op1_b = du2;
      end
      default: begin
        op0_a = '0;     op0_b = '0;   op1_a = '0;     op1_b = '0;
      end
    endcase
  end

  always_comb begin
    mac_a         = (state == S_MUL2) ? op1_a : op0_a;
    mac_b         = (state == S_MUL2) ? op1_b : op0_b;
    mac_ctrl.load = (state == S_MUL2);
    mac_ctrl.sub  = (state == S_ACC);
  end

  assign div_start = (state == S_EVAL) && (term != ttb_pkg::TERM_DET);
  assign res_idx   = term - 3'd1;

  ttb_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  ttb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (det),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      term         <= ttb_pkg::TERM_DET;
      corner_count <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || basis.ready)) begin
        out_valid <= 1'b1;
      end else if (basis.valid && basis.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (corner_count == 2'd2) begin
              corner_count <= 2'd0;
              term         <= ttb_pkg::TERM_DET;
              state        <= S_MUL1;
            end else begin
              corner_count <= corner_count + 2'd1;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_ACC;
        S_ACC:  state <= S_EVAL;
        S_EVAL: begin
          if (term == ttb_pkg::TERM_DET) begin
            if (acc == '0) begin
              state <= S_OUT;
            end else begin
              term  <= ttb_pkg::TERM_TX;
              state <= S_MUL1;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (term == ttb_pkg::TERM_BZ) begin
              state <= S_OUT;
            end else begin
              term  <= term + 3'd1;
              state <= S_MUL1;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || basis.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // corner store, deltas and results
  always_ff @(posedge clk) begin
    if (accept) begin
      if (corner_count == 2'd0) begin
        first_pos <= in_pos;
        first_tex <= in_tex;
      end else if (corner_count == 2'd1) begin
        second_pos <= in_pos;
        second_tex <= in_tex;
      end else begin
        for (int k = 0; k < 3; k++) begin
          dp1[k] <= delta(second_pos[k], first_pos[k]);
          dp2[k] <= delta(in_pos[k], first_pos[k]);
        end
        du1 <= delta(second_tex[0], first_tex[0]);
        dv1 <= delta(second_tex[1], first_tex[1]);
        du2 <= delta(in_tex[0], first_tex[0]);
        dv2 <= delta(in_tex[1], first_tex[1]);
      end
    end
    if (state == S_EVAL && term == ttb_pkg::TERM_DET) begin
      det   <= acc;
      degen <= (acc == '0);
    end
    if (state == S_DIV && div_done) begin
      res[res_idx] <= div_quo;
    end
    if (state == S_OUT && (!out_valid || basis.ready)) begin
      for (int k = 0; k < 6; k++) begin
        out_vec[k] <= degen ? '0 : res[k];
      end
      out_degen <= degen;
    end
  end

  assign basis.valid       = out_valid;
  assign basis.tangent_x   = out_vec[0];
  assign basis.tangent_y   = out_vec[1];
  assign basis.tangent_z   = out_vec[2];
  assign basis.bitangent_x = out_vec[3];
  assign basis.bitangent_y = out_vec[4];
  assign basis.bitangent_z = out_vec[5];
  assign basis.degenerate  = out_degen;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (basis.valid && basis.degenerate) |->
      (basis.tangent_x == '0 && basis.tangent_y == '0 && basis.tangent_z == '0 &&
       basis.bitangent_x == '0 && basis.bitangent_y == '0 &&
       basis.bitangent_z == '0))
    else $error("degenerate result with nonzero vectors");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(basis.valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output step");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && corner_count == 2'd2) |=>
      (state == S_MUL1 && term == ttb_pkg::TERM_DET && corner_count == 2'd0))
    else $error("third corner did not start the determinant");

endmodule
